/* hdl/pps_pkg.sv */
// Shared types and constants for the preemptive priority scheduler.
// Used by pps_select and preemptive_priority_scheduler; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

  localparam int DEF_MAX_PROCS = 16;
  localparam int ARR_W         = 12;
  localparam int BURST_W       = 12;
  localparam int PRI_W         = 8;
  localparam int TIME_W        = 17;
  localparam int PIDX_W        = 4;

  // One stored process descriptor.
  typedef struct packed {
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] burst;
    logic [PRI_W-1:0]   pri;
  } pps_desc_t;

  // Control of the selection unit during a scan.
  typedef struct packed {
    logic clr;
    logic en;
  } pps_scan_ctl_t;

  // Running winner of a scan.
  typedef struct packed {
    logic               found;
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] rem;
  } pps_pick_t;

endpackage

`default_nettype wire

/* hdl/pps_mem.sv */
// Single write port, single registered read port memory.
// Depends on nothing; instantiated by preemptive_priority_scheduler.
`timescale 1ns / 1ps
`default_nettype none

module pps_mem #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

/* hdl/pps_select.sv */
// Compare unit: keeps the ready process with the lowest priority seen so far in a scan.
// Depends on pps_pkg; instantiated by preemptive_priority_scheduler.
`timescale 1ns / 1ps
`default_nettype none

module pps_select #(
  parameter int IDX_W = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire pps_pkg::pps_scan_ctl_t      ctl,
  input  wire logic [IDX_W-1:0]            idx,
  input  wire logic                        done_bit,
  input  wire pps_pkg::pps_desc_t          desc,
  input  wire logic [pps_pkg::BURST_W-1:0] rem,
  input  wire logic [pps_pkg::TIME_W-1:0]  cur_time,
  output pps_pkg::pps_pick_t               pick,
  output logic [IDX_W-1:0]                 pick_idx
);

  import pps_pkg::*;

  logic               found_r, found_nxt;
  logic [PRI_W-1:0]   best_pri_r, best_pri_nxt;
  logic [ARR_W-1:0]   best_arr_r, best_arr_nxt;
  logic [BURST_W-1:0] best_rem_r, best_rem_nxt;
  logic [IDX_W-1:0]   pick_r, pick_nxt;
  logic               take;

  // Strict less-than keeps the lowest index on equal priority.
  assign take = ctl.en && !done_bit && (TIME_W'(desc.arr) <= cur_time) &&
                (!found_r || (desc.pri < best_pri_r));

  always_comb begin
    found_nxt    = found_r;
    best_pri_nxt = best_pri_r;
    best_arr_nxt = best_arr_r;
    best_rem_nxt = best_rem_r;
    pick_nxt     = pick_r;
    if (ctl.clr) begin
      found_nxt = 1'b0;
    end else if (take) begin
      found_nxt    = 1'b1;
      best_pri_nxt = desc.pri;
      best_arr_nxt = desc.arr;
      best_rem_nxt = rem;
      pick_nxt     = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_pri_r <= best_pri_nxt;
    best_arr_r <= best_arr_nxt;
    best_rem_r <= best_rem_nxt;
    pick_r     <= pick_nxt;
  end

  assign pick.found = found_r;
  assign pick.arr   = best_arr_r;
  assign pick.rem   = best_rem_r;
  assign pick_idx   = pick_r;

endmodule

`default_nettype wire

/* hdl/preemptive_priority_scheduler.sv */
// Preemptive priority scheduler: loads descriptors, then simulates one time unit per scan.
// Descriptors are accepted only while idle. After the last one, each time unit is a scan:
// a read of each loaded descriptor through the compare unit, one last compare, one update.
// Each result then passes through S_ERD, S_EWAIT and S_EOUT, holding in S_EOUT while the
// output stalls; input is stalled meanwhile. Synchronous active-low reset clears the
// counters, done flags and handshake state; the descriptor memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module preemptive_priority_scheduler #(
  parameter int MAX_PROCS = pps_pkg::DEF_MAX_PROCS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [pps_pkg::ARR_W-1:0]   in_arrival_time,
  input  wire logic [pps_pkg::BURST_W-1:0] in_burst_time,
  input  wire logic [pps_pkg::PRI_W-1:0]   in_priority_level,
  input  wire logic                        in_last_process,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [pps_pkg::PIDX_W-1:0]       out_process_index,
  output logic [pps_pkg::TIME_W-1:0]       out_waiting_time,
  output logic [pps_pkg::TIME_W-1:0]       out_turnaround_time,
  output logic                             out_last_result
);

  import pps_pkg::*;

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_ERD   = 3'd3;
  localparam logic [2:0] S_EWAIT = 3'd4;
  localparam logic [2:0] S_EOUT  = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     loaded_r, loaded_nxt;
  logic [CNT_W-1:0]     finished_r, finished_nxt;
  logic [TIME_W-1:0]    time_r, time_nxt;
  logic [CNT_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic                 cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic [IDX_W-1:0]     emit_idx_r, emit_idx_nxt;
  logic [MAX_PROCS-1:0] done_r, done_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [PIDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic [TIME_W-1:0]    out_wait_r, out_wait_nxt;
  logic [TIME_W-1:0]    out_tat_r, out_tat_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 in_acc;
  logic [BURST_W-1:0]   load_burst;
  pps_desc_t            desc_wdata, desc_rdata;
  logic                 desc_we;
  logic [IDX_W-1:0]     desc_raddr;
  logic                 rem_we;
  logic [IDX_W-1:0]     rem_waddr;
  logic [BURST_W-1:0]   rem_wdata, rem_rdata, rem_dec;
  logic                 tat_we;
  logic [TIME_W-1:0]    tat_wdata, tat_rdata;
  pps_scan_ctl_t        scan_ctl;
  pps_pick_t            pick;
  logic [IDX_W-1:0]     pick_idx;

  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign load_burst = (in_burst_time == '0) ? BURST_W'(1) : in_burst_time;

  assign desc_wdata.arr   = in_arrival_time;
  assign desc_wdata.burst = load_burst;
  assign desc_wdata.pri   = in_priority_level;
  assign desc_raddr       = (state_r == S_SCAN) ? scan_idx_r[IDX_W-1:0] : emit_idx_r;

  assign rem_dec   = pick.rem - 1'b1;
  assign tat_wdata = TIME_W'(time_r + 1'b1 - TIME_W'(pick.arr));

  assign scan_ctl.clr = (state_r == S_UPD);
  assign scan_ctl.en  = cmp_vld_r;

  pps_mem #(.W($bits(pps_desc_t)), .DEPTH(MAX_PROCS)) u_desc_mem (
    .clk   (clk),
    .we    (desc_we),
    .waddr (loaded_r[IDX_W-1:0]),
    .wdata (desc_wdata),
    .raddr (desc_raddr),
    .rdata (desc_rdata)
  );

  pps_mem #(.W(BURST_W), .DEPTH(MAX_PROCS)) u_rem_mem (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_waddr),
    .wdata (rem_wdata),
    .raddr (scan_idx_r[IDX_W-1:0]),
    .rdata (rem_rdata)
  );

  pps_mem #(.W(TIME_W), .DEPTH(MAX_PROCS)) u_tat_mem (
    .clk   (clk),
    .we    (tat_we),
    .waddr (pick_idx),
    .wdata (tat_wdata),
    .raddr (emit_idx_r),
    .rdata (tat_rdata)
  );

  pps_select #(.IDX_W(IDX_W)) u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (scan_ctl),
    .idx      (cmp_idx_r),
    .done_bit (done_r[cmp_idx_r]),
    .desc     (desc_rdata),
    .rem      (rem_rdata),
    .cur_time (time_r),
    .pick     (pick),
    .pick_idx (pick_idx)
  );

  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    finished_nxt  = finished_r;
    time_nxt      = time_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_vld_nxt   = 1'b0;
    emit_idx_nxt  = emit_idx_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_wait_nxt  = out_wait_r;
    out_tat_nxt   = out_tat_r;
    out_last_nxt  = out_last_r;
    desc_we       = 1'b0;
    rem_we        = 1'b0;
    rem_waddr     = loaded_r[IDX_W-1:0];
    rem_wdata     = load_burst;
    tat_we        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // A descriptor beyond capacity is dropped, but its last flag still counts.
          if (loaded_r < CNT_W'(MAX_PROCS)) begin
            desc_we    = 1'b1;
            rem_we     = 1'b1;
            loaded_nxt = loaded_r + 1'b1;
          end
          if (in_last_process) begin
            state_nxt    = S_SCAN;
            scan_idx_nxt = '0;
          end
        end
      end
      S_SCAN: begin
        // Reads are issued in the cycle before the compare that uses them.
        if (scan_idx_r == loaded_r) begin
          state_nxt = S_UPD;
        end else begin
          cmp_vld_nxt  = 1'b1;
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      S_UPD: begin
        if (pick.found) begin
          rem_we    = 1'b1;
          rem_waddr = pick_idx;
          rem_wdata = rem_dec;
          if (rem_dec == '0) begin
            done_nxt[pick_idx] = 1'b1;
            finished_nxt       = finished_r + 1'b1;
            tat_we             = 1'b1;
          end
        end
        time_nxt = time_r + 1'b1;
        if (finished_nxt == loaded_r) begin
          state_nxt    = S_ERD;
          emit_idx_nxt = '0;
        end else begin
          state_nxt    = S_SCAN;
          scan_idx_nxt = '0;
        end
      end
      S_ERD: begin
        state_nxt = S_EWAIT;
      end
      S_EWAIT: begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = PIDX_W'(emit_idx_r);
        out_tat_nxt   = tat_rdata;
        out_wait_nxt  = tat_rdata - TIME_W'(desc_rdata.burst);
        out_last_nxt  = (emit_idx_r == IDX_W'(loaded_r - 1'b1));
        state_nxt     = S_EOUT;
      end
      S_EOUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt    = S_IDLE;
            loaded_nxt   = '0;
            finished_nxt = '0;
            time_nxt     = '0;
            done_nxt     = '0;
          end else begin
            emit_idx_nxt = emit_idx_r + 1'b1;
            state_nxt    = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loaded_r    <= '0;
      finished_r  <= '0;
      time_r      <= '0;
      scan_idx_r  <= '0;
      cmp_vld_r   <= 1'b0;
      emit_idx_r  <= '0;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      finished_r  <= finished_nxt;
      time_r      <= time_nxt;
      scan_idx_r  <= scan_idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      emit_idx_r  <= emit_idx_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r  <= scan_idx_r[IDX_W-1:0];
    out_idx_r  <= out_idx_nxt;
    out_wait_r <= out_wait_nxt;
    out_tat_r  <= out_tat_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_process_index   = out_idx_r;
  assign out_waiting_time    = out_wait_r;
  assign out_turnaround_time = out_tat_r;
  assign out_last_result     = out_last_r;

`ifndef ASSERT_OFF
  a_fin_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r <= loaded_r)
    else $error("finished count exceeds loaded count");

  a_out_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_EOUT))
    else $error("result word shown outside the emit state");

  a_time_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |=> (time_r == TIME_W'($past(time_r) + 1'b1)))
    else $error("time did not advance by one unit");

  a_pick_live: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_UPD) && pick.found) |-> (!done_r[pick_idx] && (pick.rem != '0)))
    else $error("finished process selected to run");

  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EOUT) |-> (CNT_W'(emit_idx_r) < loaded_r))
    else $error("emitted index beyond loaded count");
`endif

endmodule

`default_nettype wire
